FILE: hw/rtl/asbdl_pkg.sv
// Shared constants, types and helpers for the ADC scan button block.
package asbdl_pkg;

  localparam int NUM_CHANNELS   = 3;
  localparam int BUTTON_CHANNEL = 0;
  localparam int SAMPLE_BITS    = 12;

  localparam int SAMPLE_IN_W = 12;
  localparam int THRESH_W    = 12;
  localparam int STABLE_W    = 4;
  localparam int LIMIT_W     = 12;
  localparam int STABLE_CNT_W = 5;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CHAN_OUT_W  = 2;

  // Channel index width, at least one bit.
  localparam int CHAN_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // Bits of a sample that are kept in the store.
  localparam int KEEP_W = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam bit BUTTON_VALID = (BUTTON_CHANNEL < NUM_CHANNELS);

  localparam logic [CHAN_W-1:0] SCAN_RESET = CHAN_W'(1 % NUM_CHANNELS);
  localparam logic [CHAN_W-1:0] LAST_CHAN  = CHAN_W'(NUM_CHANNELS - 1);
  localparam logic [CHAN_W-1:0] BUTTON_IDX =
    CHAN_W'(BUTTON_VALID ? BUTTON_CHANNEL : 0);

  localparam logic [STABLE_CNT_W-1:0] STABLE_MAX = '1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'hC00;
  localparam logic [STABLE_W-1:0] STABLE_RESET = 4'd3;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 12'd333;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_THRESHOLD   = 2'd0,
    CFG_STABLE_ROUNDS     = 2'd1,
    CFG_LONG_PRESS_ROUNDS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] sample_channel;
    logic [CHAN_OUT_W-1:0] next_channel;
    logic                  round_done;
    logic [KEEP_W-1:0]     button_sample;
  } scan_res_t;

  typedef struct packed {
    logic pressed;
    logic power_off;
  } btn_res_t;

  typedef struct packed {
    logic [THRESH_W-1:0] press_threshold;
    logic [STABLE_W-1:0] stable_rounds;
    logic [LIMIT_W-1:0]  long_press_rounds;
  } cfg_t;

  // Low two bits of a channel index, zero-extended for narrow indexes.
  function automatic logic [CHAN_OUT_W-1:0] chan_out(logic [CHAN_W-1:0] c);
    logic [CHAN_W+CHAN_OUT_W-1:0] w;
    w = (CHAN_W + CHAN_OUT_W)'(c);
    return w[CHAN_OUT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/asbdl_scan.sv
// Round-robin channel sequencer and button sample store.
module asbdl_scan import asbdl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_IN_W-1:0] sample_i,
  output scan_res_t              res_o
);

  logic [CHAN_W-1:0] idx_q, idx_d;
  logic [KEEP_W-1:0] btn_q, btn_d;
  logic [KEEP_W-1:0] kept;
  logic              last;
  logic              hit;

  always_comb begin
    kept  = sample_i[KEEP_W-1:0];
    last  = (idx_q >= LAST_CHAN);
    hit   = BUTTON_VALID && (idx_q == BUTTON_IDX);
    idx_d = last ? '0 : idx_q + 1'b1;
    btn_d = hit ? kept : btn_q;

    res_o.sample_channel = chan_out(idx_q);
    res_o.next_channel   = chan_out(idx_d);
    res_o.round_done     = last;
    // Forward the sample that lands on the button channel this cycle, else the stored one.
    res_o.button_sample  = BUTTON_VALID ? btn_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= SCAN_RESET;
      btn_q <= '0;
    end else if (en_i) begin
      idx_q <= idx_d;
      btn_q <= btn_d;
    end
  end

endmodule

FILE: hw/rtl/asbdl_button.sv
// Button threshold, debounce and long-press hold counter.
module asbdl_button import asbdl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              round_i,
  input  logic [KEEP_W-1:0] sample_i,
  input  cfg_t              cfg_i,
  output btn_res_t          res_o
);

  logic                    raw_q, raw_d;
  logic [STABLE_CNT_W-1:0] stable_q, stable_d;
  logic                    deb_q, deb_d;
  logic [LIMIT_W-1:0]      held_q, held_d;
  logic                    level;
  logic                    off;

  always_comb begin
    level    = (THRESH_W'(sample_i) >= cfg_i.press_threshold);
    raw_d    = raw_q;
    stable_d = stable_q;
    deb_d    = deb_q;
    held_d   = held_q;
    off      = 1'b0;

    if (round_i) begin
      if (level != raw_q) begin
        raw_d    = level;
        stable_d = '0;
      end else begin
        if (stable_q < STABLE_MAX) begin
          stable_d = stable_q + 1'b1;
        end
        if (stable_d > STABLE_CNT_W'(cfg_i.stable_rounds)) begin
          deb_d = raw_q;
        end
      end

      if (deb_d) begin
        if (held_q < cfg_i.long_press_rounds) begin
          held_d = held_q + 1'b1;
        end
      end else if (held_q >= cfg_i.long_press_rounds) begin
        off = 1'b1;
      end else begin
        held_d = '0;
      end
    end

    res_o.pressed   = deb_d;
    res_o.power_off = off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= '0;
      deb_q    <= 1'b0;
      held_q   <= '0;
    end else if (en_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      deb_q    <= deb_d;
      held_q   <= held_d;
    end
  end

endmodule

FILE: hw/rtl/adc_scan_button_debounce_longpress.sv
// Top level: ADC scan sequencer with button debounce and long-press power-off.
//
// Each input transaction carries one finished 12-bit ADC conversion for the
// channel currently selected by a three-channel round-robin scan. The block
// keeps button samples, steps the scan and, on a transaction closing a round,
// compares the button channel's sample with press_threshold, runs the
// debounce counter (raw level must repeat for more than stable_rounds rounds)
// and the saturating hold counter, and flags power_off when the button is
// released after at least long_press_rounds held rounds. Every input
// transaction yields exactly one result transaction. A transaction can be
// taken every cycle while results drain; its result is in the output register
// in the cycle after acceptance; that single output register sets the rate:
// the input stays ready while it is empty or drained in the same cycle.
// Configuration registers (index 0 press_threshold, 1 stable_rounds,
// 2 long_press_rounds) are written through cfg_we_i/cfg_index_i/cfg_data_i;
// writes to index 3 are dropped. No clearing pass is needed after reset.
module adc_scan_button_debounce_longpress import asbdl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_IN_W-1:0] sample_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CHAN_OUT_W-1:0]  sample_channel_o,
  output logic [CHAN_OUT_W-1:0]  next_channel_o,
  output logic                   round_done_o,
  output logic                   pressed_o,
  output logic                   power_off_o,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  scan_res_t scan_res;
  btn_res_t  btn_res;
  logic      in_fire;
  logic      out_valid_q, out_valid_d;

  logic [CHAN_OUT_W-1:0] sample_channel_q;
  logic [CHAN_OUT_W-1:0] next_channel_q;
  logic                  round_done_q;
  logic                  pressed_q;
  logic                  power_off_q;

  // Accept while the output register is empty or drains this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration register file.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PRESS_THRESHOLD:   cfg_d.press_threshold   = cfg_data_i[THRESH_W-1:0];
        CFG_STABLE_ROUNDS:     cfg_d.stable_rounds     = cfg_data_i[STABLE_W-1:0];
        CFG_LONG_PRESS_ROUNDS: cfg_d.long_press_rounds = cfg_data_i[LIMIT_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold   <= THRESH_RESET;
      cfg_q.stable_rounds     <= STABLE_RESET;
      cfg_q.long_press_rounds <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Channel sequencing and sample store; advance only on an accepted sample.
  asbdl_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_fire),
    .sample_i (sample_i),
    .res_o    (scan_res)
  );

  // Debounce and hold logic runs once per completed round.
  asbdl_button u_button (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_fire),
    .round_i  (scan_res.round_done),
    .sample_i (scan_res.button_sample),
    .cfg_i    (cfg_q),
    .res_o    (btn_res)
  );

  // Output register: load on accept, drop valid once the result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_channel_q <= scan_res.sample_channel;
      next_channel_q   <= scan_res.next_channel;
      round_done_q     <= scan_res.round_done;
      pressed_q        <= btn_res.pressed;
      power_off_q      <= btn_res.power_off;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_channel_o = sample_channel_q;
  assign next_channel_o   = next_channel_q;
  assign round_done_o     = round_done_q;
  assign pressed_o        = pressed_q;
  assign power_off_o      = power_off_q;

  // A completed round always wraps the scan back to channel zero.
  a_round_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && round_done_o |-> next_channel_o == '0)
    else $error("round result without wrap to channel zero");

  // Power-off only on a round end with the button released.
  a_off_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && power_off_o |-> round_done_o && !pressed_o)
    else $error("power_off outside a released round end");

  // Every accepted sample produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted sample produced no result");

endmodule
